// File: src/kot_pkg.sv
// Package with the shared types and codes of the keyed ordered client table.
package kot_pkg;

  localparam int KEY_W = 16;
  localparam int CNT_W = 16;
  localparam int POS_W = 8;
  localparam int OP_W = 3;
  localparam int ST_W = 3;
  localparam int OUT_POS_W = 5;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CNT = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_POS = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd6;

  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_POS = 3'd4;

  typedef struct packed {
    logic             is_insert;
    logic             is_remove;
    logic             is_lookup;
    logic             is_update;
    logic             is_read_cnt;
    logic             is_clear;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] pos;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: src/kot_front.sv
// Front end that accepts requests and decodes them into queued commands.
module kot_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [kot_pkg::IN_DATA_W-1:0]  in_tdata,
  input  kot_pkg::q_stat_t               q_stat,
  output logic                           push,
  output kot_pkg::cmd_t                  cmd
);

  logic [kot_pkg::OP_W-1:0] op;

  assign op = in_tdata[2:0];
  assign in_tready = !q_stat.full;
  assign push = in_tvalid && !q_stat.full;

  always_comb begin
    cmd = '0;
    cmd.key = in_tdata[18:3];
    cmd.cnt = in_tdata[34:19];
    cmd.pos = in_tdata[42:35];
    case (op)
      kot_pkg::OP_INSERT: begin
        cmd.is_insert = 1'b1;
      end
      kot_pkg::OP_REMOVE: begin
        cmd.is_remove = 1'b1;
      end
      kot_pkg::OP_SEARCH, kot_pkg::OP_READ_POS: begin
        cmd.is_lookup = 1'b1;
      end
      kot_pkg::OP_UPDATE: begin
        cmd.is_lookup = 1'b1;
        cmd.is_update = 1'b1;
      end
      kot_pkg::OP_READ_CNT: begin
        cmd.is_lookup = 1'b1;
        cmd.is_read_cnt = 1'b1;
      end
      kot_pkg::OP_CLEAR: begin
        cmd.is_clear = 1'b1;
      end
      default: begin
        cmd.is_insert = 1'b0;
      end
    endcase
  end

endmodule

// File: src/kot_queue.sv
// Two-entry command queue between the front end and the table engine.
module kot_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  kot_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output kot_pkg::cmd_t    head_cmd,
  output kot_pkg::q_stat_t q_stat
);

  kot_pkg::cmd_t mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign q_stat.full = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/kot_back.sv
// Table engine: parallel key compare, then the update of the entry row.
module kot_back #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kot_pkg::q_stat_t                q_stat,
  input  kot_pkg::cmd_t                   head_cmd,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kot_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int OCC_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]               state_r;
  logic [1:0]               state_nxt;
  kot_pkg::cmd_t            cmd_r;
  logic [ENTRIES-1:0]       match_r;
  logic [ENTRIES-1:0]       match_nxt;
  logic [ENTRIES-1:0]       first_hit;
  logic [kot_pkg::KEY_W-1:0] key_r [ENTRIES];
  logic [kot_pkg::CNT_W-1:0] cnt_r [ENTRIES];
  logic [OCC_W-1:0]         occ_r;
  logic [OCC_W-1:0]         occ_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [kot_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [kot_pkg::OUT_DATA_W-1:0] out_data_nxt;
  logic                     can_out;
  logic                     exec_fire;
  logic                     hit;
  logic [IDX_W-1:0]         slot;
  logic [kot_pkg::CNT_W-1:0] hit_cnt;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     upd_ok;
  logic                     bad_pos;
  logic                     is_full;
  logic [kot_pkg::ST_W-1:0] status;
  logic                     found;
  logic [kot_pkg::CNT_W-1:0] count_out;
  logic [kot_pkg::OUT_POS_W-1:0] pos_out;

  assign can_out = !out_valid_r || out_tready;
  assign exec_fire = (state_r == S_EXEC) && can_out;
  assign pop = !q_stat.empty && ((state_r == S_IDLE) || exec_fire);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = (32'(i) < 32'(occ_r)) && (key_r[i] == cmd_r.key);
    end
  end

  assign first_hit = match_r & (~match_r + ENTRIES'(1));
  assign hit = |match_r;

  always_comb begin
    slot = '0;
    hit_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_hit[i]) begin
        slot = slot | IDX_W'(i);
        hit_cnt = hit_cnt | cnt_r[i];
      end
    end
  end

  assign is_full = (occ_r == OCC_W'(ENTRIES));
  assign bad_pos = (cmd_r.pos == '0) || (32'(cmd_r.pos) > 32'(occ_r));
  assign ins_ok = cmd_r.is_insert && !hit && !is_full;
  assign rem_ok = cmd_r.is_remove && !bad_pos;
  assign upd_ok = cmd_r.is_update && hit;

  always_comb begin
    status = kot_pkg::ST_OK;
    found = 1'b0;
    count_out = '0;
    pos_out = '0;
    occ_nxt = occ_r;
    if (cmd_r.is_insert) begin
      if (hit) begin
        status = kot_pkg::ST_DUPLICATE;
        found = 1'b1;
        pos_out = kot_pkg::OUT_POS_W'(OCC_W'(slot) + OCC_W'(1));
      end else if (is_full) begin
        status = kot_pkg::ST_FULL;
      end else begin
        occ_nxt = occ_r + OCC_W'(1);
        pos_out = kot_pkg::OUT_POS_W'(occ_nxt);
      end
    end else if (cmd_r.is_remove) begin
      if (bad_pos) begin
        status = kot_pkg::ST_BAD_POS;
      end else begin
        occ_nxt = occ_r - OCC_W'(1);
      end
    end else if (cmd_r.is_lookup) begin
      if (!hit) begin
        status = kot_pkg::ST_NOT_FOUND;
      end else begin
        found = 1'b1;
        pos_out = kot_pkg::OUT_POS_W'(OCC_W'(slot) + OCC_W'(1));
        if (cmd_r.is_read_cnt) begin
          count_out = hit_cnt;
        end
      end
    end else if (cmd_r.is_clear) begin
      occ_nxt = '0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[2:0] = status;
    out_data_nxt[3] = found;
    out_data_nxt[19:4] = count_out;
    out_data_nxt[24:20] = pos_out;
    out_data_nxt[29:25] = kot_pkg::OUT_POS_W'(occ_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (can_out) begin
          state_nxt = q_stat.empty ? S_IDLE : S_MATCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_fire) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
    if (state_r == S_MATCH) begin
      match_r <= match_nxt;
    end
    if (exec_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (ins_ok && (occ_r == OCC_W'(i))) begin
          key_r[i] <= cmd_r.key;
          cnt_r[i] <= cmd_r.cnt;
        end
        if (upd_ok && first_hit[i]) begin
          cnt_r[i] <= cmd_r.cnt;
        end
      end
      for (int i = 0; i < ENTRIES - 1; i++) begin
        if (rem_ok && ((32'(i) + 32'd1) >= 32'(cmd_r.pos))) begin
          key_r[i] <= key_r[i + 1];
          cnt_r[i] <= cnt_r[i + 1];
        end
      end
    end
  end

endmodule

// File: src/keyed_ordered_client_table.sv
// Top level of the keyed ordered client table with its request queue and engine.
// A request passes the queue, the command register, the match register and the result register.
// The engine takes one request at a time through its compare and update steps; a held result stalls it.
// A two-entry queue takes requests while the engine works or a result waits.
// Reset (rst_n, synchronous, active low) empties the table and the queue.
module keyed_ordered_client_table #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: req_type, client_key, pending_count, position.
  input  logic [kot_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: status, found, count_out, position_out, entries_used.
  output logic [kot_pkg::OUT_DATA_W-1:0]  out_tdata
);

  kot_pkg::q_stat_t q_stat;
  kot_pkg::cmd_t    push_cmd;
  kot_pkg::cmd_t    head_cmd;
  logic             push;
  logic             pop;

  kot_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  kot_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  kot_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= kot_pkg::ST_BAD_POS))
    else $error("result status code out of range");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3]) |->
      (out_tdata[2:0] == kot_pkg::ST_OK || out_tdata[2:0] == kot_pkg::ST_DUPLICATE))
    else $error("found flag with an error status");

  a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2:0] == kot_pkg::ST_NOT_FOUND) |->
      (!out_tdata[3] && out_tdata[19:4] == '0 && out_tdata[24:20] == '0))
    else $error("missing key reported with data");

endmodule

// File: dv/kot_reply_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every reply of the keyed ordered client table and compares it.
module kot_reply_checker #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [kot_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [kot_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             outstanding
);

  typedef struct packed {
    logic [kot_pkg::ST_W-1:0]      status;
    logic                          found;
    logic [kot_pkg::CNT_W-1:0]     count;
    logic [kot_pkg::OUT_POS_W-1:0] where;
    logic [kot_pkg::OUT_POS_W-1:0] used;
  } reply_t;

  logic [kot_pkg::KEY_W-1:0] key_slot[ENTRIES];
  logic [kot_pkg::CNT_W-1:0] count_slot[ENTRIES];
  int occupied;
  reply_t reply_queue[$];

  // The first matching slot in arrival order wins; -1 means the key is absent.
  function automatic int slot_of(input logic [kot_pkg::KEY_W-1:0] key);
    for (int i = 0; i < occupied; i++) begin
      if (key_slot[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic reply_t serve_request(input logic [kot_pkg::IN_DATA_W-1:0] word);
    logic [kot_pkg::OP_W-1:0]  op;
    logic [kot_pkg::KEY_W-1:0] key;
    logic [kot_pkg::CNT_W-1:0] cnt;
    logic [kot_pkg::POS_W-1:0] pos;
    int slot;
    reply_t r;
    op = word[kot_pkg::OP_W-1:0];
    key = word[kot_pkg::OP_W +: kot_pkg::KEY_W];
    cnt = word[kot_pkg::OP_W+kot_pkg::KEY_W +: kot_pkg::CNT_W];
    pos = word[kot_pkg::OP_W+kot_pkg::KEY_W+kot_pkg::CNT_W +: kot_pkg::POS_W];
    r = '0;
    case (op)
      kot_pkg::OP_INSERT: begin
        slot = slot_of(key);
        if (slot >= 0) begin
          r.status = kot_pkg::ST_DUPLICATE;
          r.found = 1'b1;
          r.where = kot_pkg::OUT_POS_W'(slot + 1);
        end else if (occupied >= ENTRIES) begin
          r.status = kot_pkg::ST_FULL;
        end else begin
          key_slot[occupied] = key;
          count_slot[occupied] = cnt;
          occupied++;
          r.where = kot_pkg::OUT_POS_W'(occupied);
        end
      end
      kot_pkg::OP_REMOVE: begin
        if (pos == 0 || pos > occupied) begin
          r.status = kot_pkg::ST_BAD_POS;
        end else begin
          for (int i = pos - 1; i + 1 < occupied; i++) begin
            key_slot[i] = key_slot[i + 1];
            count_slot[i] = count_slot[i + 1];
          end
          occupied--;
        end
      end
      kot_pkg::OP_SEARCH, kot_pkg::OP_UPDATE, kot_pkg::OP_READ_CNT,
      kot_pkg::OP_READ_POS: begin
        slot = slot_of(key);
        if (slot < 0) begin
          r.status = kot_pkg::ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.where = kot_pkg::OUT_POS_W'(slot + 1);
          if (op == kot_pkg::OP_UPDATE) begin
            count_slot[slot] = cnt;
          end else if (op == kot_pkg::OP_READ_CNT) begin
            r.count = count_slot[slot];
          end
        end
      end
      kot_pkg::OP_CLEAR: begin
        occupied = 0;
      end
      default: begin
      end
    endcase
    r.used = kot_pkg::OUT_POS_W'(occupied);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      occupied = 0;
      fail_count = 0;
      reply_queue.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (reply_queue.size() == 0) begin
          $error("result transaction with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          want = reply_queue.pop_front();
          check_field("status", int'(want.status), int'(out_tdata[2:0]));
          check_field("found", int'(want.found), int'(out_tdata[3]));
          check_field("count_out", int'(want.count), int'(out_tdata[19:4]));
          check_field("position_out", int'(want.where), int'(out_tdata[24:20]));
          check_field("entries_used", int'(want.used), int'(out_tdata[29:25]));
        end
      end
      if (in_tvalid && in_tready) begin
        reply_queue.push_back(serve_request(in_tdata));
      end
    end
    outstanding <= reply_queue.size();
  end

endmodule

// File: dv/keyed_ordered_client_table_tb.sv
`timescale 1ns / 1ps
// Testbench top that drives requests into the keyed ordered client table and gives the verdict.
module keyed_ordered_client_table_tb;

  localparam logic [kot_pkg::OP_W-1:0] OP_NOP = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 145;
  localparam int POOL_SIZE = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [kot_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tready = 1'b0;
  wire in_tready;
  wire out_tvalid;
  wire [kot_pkg::OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int send_idle = 0;
  int recv_stall = 0;
  int cycle_count = 0;
  logic [kot_pkg::KEY_W-1:0] key_pool[POOL_SIZE];

  always #2 clk = ~clk;

  keyed_ordered_client_table DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  kot_reply_checker checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("keyed_ordered_client_table_tb: done, errors");
      $finish;
    end
  end

  task automatic send_request(input logic [kot_pkg::OP_W-1:0] op,
                              input logic [kot_pkg::KEY_W-1:0] key,
                              input logic [kot_pkg::CNT_W-1:0] cnt,
                              input logic [kot_pkg::POS_W-1:0] pos);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, pos, cnt, key, op};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Keys come mostly from a small pool so that hits, duplicates and a full table are common.
  task automatic send_random_request();
    int pick;
    logic [kot_pkg::OP_W-1:0] op;
    logic [kot_pkg::KEY_W-1:0] key;
    logic [kot_pkg::POS_W-1:0] pos;
    pick = $urandom_range(0, 99);
    if (pick < 34) op = kot_pkg::OP_INSERT;
    else if (pick < 46) op = kot_pkg::OP_REMOVE;
    else if (pick < 56) op = kot_pkg::OP_SEARCH;
    else if (pick < 68) op = kot_pkg::OP_UPDATE;
    else if (pick < 80) op = kot_pkg::OP_READ_CNT;
    else if (pick < 90) op = kot_pkg::OP_READ_POS;
    else if (pick < 92) op = kot_pkg::OP_CLEAR;
    else if (pick < 95) op = OP_NOP;
    else op = kot_pkg::OP_INSERT;
    if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else key = kot_pkg::KEY_W'($urandom);
    if ($urandom_range(0, 99) < 85) pos = kot_pkg::POS_W'($urandom_range(0, 17));
    else pos = kot_pkg::POS_W'($urandom_range(0, 255));
    send_request(op, key, kot_pkg::CNT_W'($urandom), pos);
  endtask

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    idle_plan = '{0, 62, 0, 9};
    stall_plan = '{0, 0, 62, 9};
    foreach (key_pool[i]) key_pool[i] = kot_pkg::KEY_W'($urandom);
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_request(kot_pkg::OP_INSERT, 16'h0000, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(kot_pkg::OP_INSERT, 16'h0000, 16'h1234, 8'd1);
    send_request(kot_pkg::OP_SEARCH, 16'hFFFF, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_SEARCH, 16'h1234, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_UPDATE, 16'hFFFF, 16'h8000, 8'd0);
    send_request(kot_pkg::OP_READ_CNT, 16'hFFFF, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_READ_POS, 16'h0000, 16'hFFFF, 8'd0);
    send_request(kot_pkg::OP_READ_CNT, 16'hABCD, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_UPDATE, 16'hABCD, 16'h5555, 8'd0);
    send_request(kot_pkg::OP_READ_POS, 16'h7FFF, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_REMOVE, 16'h0000, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_REMOVE, 16'h0000, 16'h0000, 8'hFF);
    send_request(kot_pkg::OP_REMOVE, 16'h0000, 16'h0000, 8'd3);
    send_request(kot_pkg::OP_REMOVE, 16'h0000, 16'h0000, 8'd2);
    send_request(kot_pkg::OP_REMOVE, 16'h0000, 16'h0000, 8'd1);
    send_request(OP_NOP, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(kot_pkg::OP_INSERT, 16'h8001, 16'h00FF, 8'd0);
    send_request(kot_pkg::OP_INSERT, 16'h0001, 16'hFF00, 8'd0);
    send_request(kot_pkg::OP_READ_CNT, 16'h0001, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_CLEAR, 16'h0000, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_CLEAR, 16'h0000, 16'h0000, 8'd0);
    send_request(kot_pkg::OP_REMOVE, 16'h0000, 16'h0000, 8'd1);
    send_request(kot_pkg::OP_SEARCH, 16'h8001, 16'h0000, 8'd0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = idle_plan[phase];
      recv_stall = stall_plan[phase];
      repeat (RANDOM_PER_PHASE) send_random_request();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("keyed_ordered_client_table_tb: done, clean");
    end else begin
      $display("keyed_ordered_client_table_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/kot_pkg.sv
src/kot_front.sv
src/kot_queue.sv
src/kot_back.sv
src/keyed_ordered_client_table.sv
dv/kot_reply_checker.sv
dv/keyed_ordered_client_table_tb.sv
